### design/spq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spq_pkg
// Shared types and constants for the sorted priority queue.
// ----------------------------------------------------------------------------
package spq_pkg;

    localparam int DEPTH_DEF      = 16;
    localparam int VALUE_BITS_DEF = 16;

    localparam int TAG_W   = 16;
    localparam int PRI_W   = 8;
    localparam int STAT_W  = 2;
    localparam int COUNT_W = 5;

    localparam logic CMD_ENQ = 1'b0;
    localparam logic CMD_DEQ = 1'b1;

    typedef enum logic [STAT_W-1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    typedef struct packed {
        logic enq;
        logic deq;
    } t_cell_ctrl;

endpackage

### design/sorted_priority_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_priority_queue
// Bounded priority queue held as a sorted chain of cells, head in cell 0.
// ----------------------------------------------------------------------------
// Each beat is an enqueue or a dequeue and yields one registered result beat,
// carrying the dequeued entry, a status, the count and the new head.
// The block takes one beat per cycle unless a held result is stalled, which
// stalls the input: every cell compares its priority with the incoming one in
// parallel and the chain shifts together. Equal priorities leave in arrival
// order; an enqueue on a full queue is dropped and flagged.
module sorted_priority_queue #(
    parameter int DEPTH      = spq_pkg::DEPTH_DEF,
    parameter int VALUE_BITS = spq_pkg::VALUE_BITS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  logic                         i_cmd,
    input  logic [spq_pkg::TAG_W-1:0]    i_value_tag,
    input  logic [spq_pkg::PRI_W-1:0]    i_priority_req,
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output logic [spq_pkg::STAT_W-1:0]   o_status,
    output logic [spq_pkg::TAG_W-1:0]    o_out_value,
    output logic [spq_pkg::PRI_W-1:0]    o_out_priority,
    output logic                         o_is_empty,
    output logic [spq_pkg::COUNT_W-1:0]  o_entry_count,
    output logic [spq_pkg::TAG_W-1:0]    o_head_value,
    output logic [spq_pkg::PRI_W-1:0]    o_head_priority
);

    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [CNT_W-1:0]          r_count, n_count;
    logic                      r_out_valid;
    spq_pkg::t_status          r_status, n_status;
    logic [spq_pkg::TAG_W-1:0] r_out_value, n_out_value;
    logic [spq_pkg::PRI_W-1:0] r_out_pri, n_out_pri;
    logic                      r_empty;
    logic [CNT_W-1:0]          r_cnt_out;
    logic [spq_pkg::TAG_W-1:0] r_head_value, n_head_value;
    logic [spq_pkg::PRI_W-1:0] r_head_pri, n_head_pri;

    logic                      w_accept;
    logic                      w_full;
    logic                      w_empty;
    logic [VALUE_BITS-1:0]     w_tag;
    spq_pkg::t_cell_ctrl       w_ctrl;

    logic                      w_le  [DEPTH];
    logic [VALUE_BITS-1:0]     w_val [DEPTH];
    logic [spq_pkg::PRI_W-1:0] w_pri [DEPTH];

    assign o_in_stall = r_out_valid && i_out_stall;
    assign w_accept   = i_in_valid && !o_in_stall;
    assign w_full     = (r_count == CNT_W'(DEPTH));
    assign w_empty    = (r_count == '0);
    assign w_tag      = VALUE_BITS'(i_value_tag);

    assign w_ctrl.enq = w_accept && (i_cmd == spq_pkg::CMD_ENQ) && !w_full;
    assign w_ctrl.deq = w_accept && (i_cmd == spq_pkg::CMD_DEQ) && !w_empty;

    for (genvar k = 0; k < DEPTH; k++) begin : g_cell
        logic                      w_left_le;
        logic [VALUE_BITS-1:0]     w_left_val;
        logic [spq_pkg::PRI_W-1:0] w_left_pri;
        logic [VALUE_BITS-1:0]     w_right_val;
        logic [spq_pkg::PRI_W-1:0] w_right_pri;

        if (k == 0) begin : g_first
            assign w_left_le  = 1'b1;
            assign w_left_val = '0;
            assign w_left_pri = '0;
        end else begin : g_mid
            assign w_left_le  = w_le[k-1];
            assign w_left_val = w_val[k-1];
            assign w_left_pri = w_pri[k-1];
        end

        if (k == DEPTH - 1) begin : g_last
            assign w_right_val = '0;
            assign w_right_pri = '0;
        end else begin : g_inner
            assign w_right_val = w_val[k+1];
            assign w_right_pri = w_pri[k+1];
        end

        spq_cell #(
            .VALUE_BITS (VALUE_BITS)
        ) u_cell (
            .i_clk       (i_clk),
            .i_ctrl      (w_ctrl),
            .i_occ       (r_count > CNT_W'(k)),
            .i_new_val   (w_tag),
            .i_new_pri   (i_priority_req),
            .i_left_le   (w_left_le),
            .i_left_val  (w_left_val),
            .i_left_pri  (w_left_pri),
            .i_right_val (w_right_val),
            .i_right_pri (w_right_pri),
            .o_le        (w_le[k]),
            .o_val       (w_val[k]),
            .o_pri       (w_pri[k])
        );
    end

    always_comb begin
        n_count      = r_count;
        n_status     = spq_pkg::ST_OK;
        n_out_value  = '0;
        n_out_pri    = '0;
        n_head_value = w_empty ? '0 : spq_pkg::TAG_W'(w_val[0]);
        n_head_pri   = w_empty ? '0 : w_pri[0];
        if (i_cmd == spq_pkg::CMD_ENQ) begin
            if (w_full) begin
                n_status = spq_pkg::ST_FULL;
            end else begin
                n_count = r_count + 1'b1;
                if (!w_le[0]) begin
                    n_head_value = spq_pkg::TAG_W'(w_tag);
                    n_head_pri   = i_priority_req;
                end
            end
        end else begin
            if (w_empty) begin
                n_status = spq_pkg::ST_EMPTY;
            end else begin
                n_count     = r_count - 1'b1;
                n_out_value = spq_pkg::TAG_W'(w_val[0]);
                n_out_pri   = w_pri[0];
                if (r_count == CNT_W'(1)) begin
                    n_head_value = '0;
                    n_head_pri   = '0;
                end else begin
                    n_head_value = spq_pkg::TAG_W'(w_val[1]);
                    n_head_pri   = w_pri[1];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_accept) begin
                r_count <= n_count;
            end
            if (w_accept) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_status     <= n_status;
            r_out_value  <= n_out_value;
            r_out_pri    <= n_out_pri;
            r_empty      <= (n_count == '0);
            r_cnt_out    <= n_count;
            r_head_value <= n_head_value;
            r_head_pri   <= n_head_pri;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_status        = r_status;
    assign o_out_value     = r_out_value;
    assign o_out_priority  = r_out_pri;
    assign o_is_empty      = r_empty;
    assign o_entry_count   = spq_pkg::COUNT_W'(r_cnt_out);
    assign o_head_value    = r_head_value;
    assign o_head_priority = r_head_pri;

endmodule

### design/spq_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spq_cell
// One slot of the sorted chain: keeps its entry, takes the new entry, or
// takes its left or right neighbor's entry.
// ----------------------------------------------------------------------------
module spq_cell #(
    parameter int VALUE_BITS = spq_pkg::VALUE_BITS_DEF
) (
    input  logic                       i_clk,
    input  spq_pkg::t_cell_ctrl        i_ctrl,
    input  logic                       i_occ,
    input  logic [VALUE_BITS-1:0]      i_new_val,
    input  logic [spq_pkg::PRI_W-1:0]  i_new_pri,
    input  logic                       i_left_le,
    input  logic [VALUE_BITS-1:0]      i_left_val,
    input  logic [spq_pkg::PRI_W-1:0]  i_left_pri,
    input  logic [VALUE_BITS-1:0]      i_right_val,
    input  logic [spq_pkg::PRI_W-1:0]  i_right_pri,
    output logic                       o_le,
    output logic [VALUE_BITS-1:0]      o_val,
    output logic [spq_pkg::PRI_W-1:0]  o_pri
);

    logic [VALUE_BITS-1:0]     r_val, n_val;
    logic [spq_pkg::PRI_W-1:0] r_pri, n_pri;

    assign o_le  = i_occ && (r_pri <= i_new_pri);
    assign o_val = r_val;
    assign o_pri = r_pri;

    always_comb begin
        n_val = r_val;
        n_pri = r_pri;
        if (i_ctrl.enq && !o_le) begin
            if (i_left_le) begin
                n_val = i_new_val;
                n_pri = i_new_pri;
            end else begin
                n_val = i_left_val;
                n_pri = i_left_pri;
            end
        end else if (i_ctrl.deq) begin
            n_val = i_right_val;
            n_pri = i_right_pri;
        end
    end

    always_ff @(posedge i_clk) begin
        r_val <= n_val;
        r_pri <= n_pri;
    end

endmodule

### dv/spq_scoreboard_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spq_scoreboard_pkg
// Result tracking for the sorted priority queue testbench.
// ----------------------------------------------------------------------------
// Keeps a sorted copy of the queue contents. Every accepted command beat is
// applied to that copy and the result it must produce is queued; every
// result beat from the block is compared field by field with the oldest one.
package spq_scoreboard_pkg;

    import spq_pkg::*;

    localparam int MAX_PRINT = 40;
    localparam logic [TAG_W-1:0] TAG_KEEP = TAG_W'((64'd1 << VALUE_BITS_DEF) - 1);

    typedef struct {
        t_status              status;
        logic [TAG_W-1:0]     out_value;
        logic [PRI_W-1:0]     out_priority;
        logic                 is_empty;
        logic [COUNT_W-1:0]   entry_count;
        logic [TAG_W-1:0]     head_value;
        logic [PRI_W-1:0]     head_priority;
    } t_result;

    class spq_scoreboard;

        logic [TAG_W-1:0] slot_tag [DEPTH_DEF];
        logic [PRI_W-1:0] slot_pri [DEPTH_DEF];
        int unsigned      fill;
        t_result          owed_results [$];

        int unsigned errors;
        int unsigned beats_in;
        int unsigned results_seen;
        int unsigned full_drops;
        int unsigned empty_pops;
        int unsigned max_fill;

        function new();
            fill         = 0;
            errors       = 0;
            beats_in     = 0;
            results_seen = 0;
            full_drops   = 0;
            empty_pops   = 0;
            max_fill     = 0;
        endfunction

        task report(string msg);
            if (errors < MAX_PRINT) begin
                $display("[%0t] MISMATCH: %s", $realtime, msg);
            end
            errors++;
        endtask

        // apply one command beat to the sorted copy and queue its result
        function void push_command(logic cmd, logic [TAG_W-1:0] tag, logic [PRI_W-1:0] pri);
            t_result     r;
            int unsigned pos;
            int unsigned i;
            r.status       = ST_OK;
            r.out_value    = '0;
            r.out_priority = '0;
            beats_in++;
            if (cmd == CMD_ENQ) begin
                if (fill >= DEPTH_DEF) begin
                    r.status = ST_FULL;
                    full_drops++;
                end else begin
                    pos = 0;
                    while (pos < fill && slot_pri[pos] <= pri) pos++;
                    for (i = fill; i > pos; i--) begin
                        slot_tag[i] = slot_tag[i-1];
                        slot_pri[i] = slot_pri[i-1];
                    end
                    slot_tag[pos] = tag & TAG_KEEP;
                    slot_pri[pos] = pri;
                    fill++;
                    if (fill > max_fill) max_fill = fill;
                end
            end else begin
                if (fill == 0) begin
                    r.status = ST_EMPTY;
                    empty_pops++;
                end else begin
                    r.out_value    = slot_tag[0];
                    r.out_priority = slot_pri[0];
                    for (i = 1; i < fill; i++) begin
                        slot_tag[i-1] = slot_tag[i];
                        slot_pri[i-1] = slot_pri[i];
                    end
                    fill--;
                end
            end
            r.is_empty      = (fill == 0);
            r.entry_count   = COUNT_W'(fill);
            r.head_value    = (fill != 0) ? slot_tag[0] : '0;
            r.head_priority = (fill != 0) ? slot_pri[0] : '0;
            owed_results.push_back(r);
        endfunction

        task cmp(string field, logic [15:0] got, logic [15:0] want);
            if (got !== want) begin
                report($sformatf("result %0d %s: got %0h want %0h",
                                 results_seen, field, got, want));
            end
        endtask

        task match_result(t_result got);
            t_result want;
            if (owed_results.size() == 0) begin
                report($sformatf("result beat with nothing owed, status %0h", got.status));
                return;
            end
            want = owed_results.pop_front();
            cmp("status",        got.status,        want.status);
            cmp("out_value",     got.out_value,     want.out_value);
            cmp("out_priority",  got.out_priority,  want.out_priority);
            cmp("is_empty",      got.is_empty,      want.is_empty);
            cmp("entry_count",   got.entry_count,   want.entry_count);
            cmp("head_value",    got.head_value,    want.head_value);
            cmp("head_priority", got.head_priority, want.head_priority);
            results_seen++;
        endtask

    endclass

endpackage

### dv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Regression bench for the sorted priority queue.
// ----------------------------------------------------------------------------
// A directed opening fills the queue with edge priorities and tags, overflows
// it and pops from empty; random phases then mix, fill, drain and tie-heavy
// traffic with random gaps on the command side and random stall on the
// result side. Every result beat is checked against a sorted shadow copy.
module tb;

    import spq_pkg::*;
    import spq_scoreboard_pkg::*;

    typedef enum int {
        PH_MIXED,
        PH_TIES,
        PH_FILL,
        PH_DRAIN
    } t_phase;

    localparam int RANDOM_BEATS = 1150;

    logic                i_clk;
    logic                i_rst_n;
    logic                i_in_valid;
    logic                o_in_stall;
    logic                i_cmd;
    logic [TAG_W-1:0]    i_value_tag;
    logic [PRI_W-1:0]    i_priority_req;
    logic                o_out_valid;
    logic                i_out_stall;
    logic [STAT_W-1:0]   o_status;
    logic [TAG_W-1:0]    o_out_value;
    logic [PRI_W-1:0]    o_out_priority;
    logic                o_is_empty;
    logic [COUNT_W-1:0]  o_entry_count;
    logic [TAG_W-1:0]    o_head_value;
    logic [PRI_W-1:0]    o_head_priority;

    spq_scoreboard sb = new();
    bit            no_idle = 1'b0;
    int unsigned   sent = 0;

    sorted_priority_queue #(
        .DEPTH      (DEPTH_DEF),
        .VALUE_BITS (VALUE_BITS_DEF)
    ) dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_cmd           (i_cmd),
        .i_value_tag     (i_value_tag),
        .i_priority_req  (i_priority_req),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_status        (o_status),
        .o_out_value     (o_out_value),
        .o_out_priority  (o_out_priority),
        .o_is_empty      (o_is_empty),
        .o_entry_count   (o_entry_count),
        .o_head_value    (o_head_value),
        .o_head_priority (o_head_priority)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // input beats are noted before result beats are checked in the same edge
    always @(posedge i_clk) begin
        t_result got;
        if (i_rst_n) begin
            if (i_in_valid && !o_in_stall) begin
                sb.push_command(i_cmd, i_value_tag, i_priority_req);
            end
            if (o_out_valid && !i_out_stall) begin
                got.status        = t_status'(o_status);
                got.out_value     = o_out_value;
                got.out_priority  = o_out_priority;
                got.is_empty      = o_is_empty;
                got.entry_count   = o_entry_count;
                got.head_value    = o_head_value;
                got.head_priority = o_head_priority;
                sb.match_result(got);
            end
        end
    end

    // result side: per beat, optionally stall at random, then take it
    initial begin
        int n;
        i_out_stall <= 1'b0;
        do @(posedge i_clk); while (!i_rst_n);
        forever begin
            n = no_idle ? 0 : $urandom_range(0, 8);
            if (n > 0) begin
                i_out_stall <= 1'b1;
                repeat (n) @(posedge i_clk);
            end
            i_out_stall <= 1'b0;
            do @(posedge i_clk); while (o_out_valid !== 1'b1);
        end
    end

    task automatic send_beat(input logic cmd, input logic [TAG_W-1:0] tag,
                             input logic [PRI_W-1:0] pri);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 8);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid     <= 1'b1;
        i_cmd          <= cmd;
        i_value_tag    <= tag;
        i_priority_req <= pri;
        do @(posedge i_clk); while (o_in_stall);
        sent++;
    endtask

    // drop valid right after the last accepted beat, then wait out all results
    task automatic hold_until_drained();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (sb.owed_results.size() != 0);
    endtask

    initial begin
        logic [TAG_W-1:0] fill_tag [DEPTH_DEF] = '{
            16'h0000, 16'hFFFF, 16'h1234, 16'hA5A5, 16'h5A5A, 16'h0001, 16'h8000, 16'h00FF,
            16'hFF00, 16'h1111, 16'h2222, 16'h3333, 16'h4444, 16'h5555, 16'h6666, 16'h7777
        };
        logic [PRI_W-1:0] fill_pri [DEPTH_DEF] = '{
            8'h00, 8'hFF, 8'h00, 8'h80, 8'h80, 8'h7F, 8'h01, 8'hFF,
            8'h40, 8'h80, 8'h10, 8'h10, 8'hFE, 8'h02, 8'h00, 8'hFF
        };
        t_phase      ph;
        int          len;
        int          roll;
        logic        cmd;
        logic [TAG_W-1:0] tag;
        logic [PRI_W-1:0] pri;
        int unsigned rand_start;

        i_rst_n        <= 1'b0;
        i_in_valid     <= 1'b0;
        i_cmd          <= CMD_ENQ;
        i_value_tag    <= '0;
        i_priority_req <= '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: pop from empty, fill with edge values and ties, overflow
        send_beat(CMD_DEQ, 16'hFFFF, 8'hFF);
        for (int k = 0; k < DEPTH_DEF; k++) send_beat(CMD_ENQ, fill_tag[k], fill_pri[k]);
        send_beat(CMD_ENQ, 16'h9999, 8'h00);
        repeat (4) send_beat(CMD_DEQ, 16'h0000, 8'h00);
        hold_until_drained();

        rand_start = sent;
        ph = PH_FILL;
        while (sent - rand_start < RANDOM_BEATS) begin
            len     = $urandom_range(30, 70);
            no_idle = ($urandom_range(0, 3) == 0);
            repeat (len) begin
                roll = $urandom_range(0, 99);
                tag  = TAG_W'($urandom);
                pri  = PRI_W'($urandom);
                case (ph)
                    PH_MIXED: cmd = (roll < 55) ? CMD_ENQ : CMD_DEQ;
                    PH_TIES: begin
                        cmd = (roll < 50) ? CMD_ENQ : CMD_DEQ;
                        pri = ($urandom_range(0, 4) == 0) ? {PRI_W{pri[0]}} :
                              PRI_W'($urandom_range(0, 3));
                    end
                    PH_FILL:  cmd = (roll < 90) ? CMD_ENQ : CMD_DEQ;
                    default:  cmd = (roll < 10) ? CMD_ENQ : CMD_DEQ;
                endcase
                send_beat(cmd, tag, pri);
            end
            if ($urandom_range(0, 2) == 0) hold_until_drained();
            ph = t_phase'($urandom_range(0, 3));
        end
        no_idle = 1'b0;

        hold_until_drained();
        repeat (8) @(posedge i_clk);
        if (sb.owed_results.size() != 0) begin
            sb.report($sformatf("%0d results never arrived", sb.owed_results.size()));
        end

        $display("covered %0d command beats, %0d results checked, peak fill %0d",
                 sb.beats_in, sb.results_seen, sb.max_fill);
        $display("overflow drops %0d, pops from empty %0d, mismatches %0d",
                 sb.full_drops, sb.empty_pops, sb.errors);
        if (sb.errors == 0) begin
            $display("sorted_priority_queue regression: pass");
        end else begin
            $display("sorted_priority_queue regression: fail");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("timeout at %0t", $realtime);
        $display("sorted_priority_queue regression: fail");
        $finish;
    end

endmodule

### files.f
design/spq_pkg.sv
design/spq_cell.sv
design/sorted_priority_queue.sv
dv/spq_scoreboard_pkg.sv
dv/tb.sv
